@@ rtl/core/psd3d_pkg.sv @@
// ----------------------------------------------------------------------------
// Point to segment distance package
// Shared result width, case codes and the tag that travels with each item.
// ----------------------------------------------------------------------------
package psd3d_pkg;

   localparam int DIST_BITS = 25;

   typedef logic [1:0] case_type;

   localparam case_type CASE_DEGEN    = 2'd0;
   localparam case_type CASE_NEAR_A   = 2'd1;
   localparam case_type CASE_NEAR_B   = 2'd2;
   localparam case_type CASE_INTERIOR = 2'd3;

   typedef struct packed {
      logic     sat;
      case_type kase;
   } tag_type;

endpackage

@@ rtl/core/psd3d_req_if.sv @@
// ----------------------------------------------------------------------------
// Query channel
// Valid/ready channel that carries segment endpoints A, B and point P.
// ----------------------------------------------------------------------------
interface psd3d_req_if #(parameter int COORD_BITS = 24);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] a_x;
   logic signed [COORD_BITS-1:0] a_y;
   logic signed [COORD_BITS-1:0] a_z;
   logic signed [COORD_BITS-1:0] b_x;
   logic signed [COORD_BITS-1:0] b_y;
   logic signed [COORD_BITS-1:0] b_z;
   logic signed [COORD_BITS-1:0] p_x;
   logic signed [COORD_BITS-1:0] p_y;
   logic signed [COORD_BITS-1:0] p_z;

   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, p_x, p_y, p_z,
                   input ready);
   modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, p_x, p_y, p_z,
                 output ready);
endinterface

@@ rtl/core/psd3d_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the distance and the nearest case code.
// ----------------------------------------------------------------------------
interface psd3d_rsp_if;
   import psd3d_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [DIST_BITS-1:0] distance;
   logic [1:0]           nearest_case;

   modport source (output valid, distance, nearest_case, input ready);
   modport sink (input valid, distance, nearest_case, output ready);
endinterface

@@ rtl/core/psd3d_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, with an overflow check in front.
// ----------------------------------------------------------------------------
module psd3d_div
   import psd3d_pkg::*;
#(
   parameter int NW   = 102,
   parameter int DENW = 51,
   parameter int QB   = 50
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  tag_type         in_tag,
   input  logic [NW-1:0]   num,
   input  logic [DENW-1:0] den,
   output logic            out_valid,
   output tag_type         out_tag,
   output logic [QB-1:0]   quot
);

   localparam int TW = DENW + QB;
   localparam int EW = (NW > TW) ? NW : TW;

   logic [QB:0]     v_ff;
   tag_type         tag_ff [QB+1];
   logic [NW-1:0]   rem_ff [QB+1];
   logic [DENW-1:0] den_ff [QB+1];
   logic [QB-1:0]   q_ff   [QB+1];

   logic [NW-1:0] num_hi;
   logic          sat_in;

   assign num_hi = num >> QB;
   assign sat_in = num_hi >= NW'(den);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= '{sat: sat_in, kase: in_tag.kase};
         rem_ff[0] <= sat_in ? '0 : num;
         den_ff[0] <= den;
         q_ff[0]   <= '0;
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_stage
      localparam int B = QB - 1 - k;
      logic [EW-1:0] trial;
      logic [EW-1:0] rem_ext;
      logic          take;
      logic [QB-1:0] q_in;

      assign trial   = EW'(den_ff[k]) << B;
      assign rem_ext = EW'(rem_ff[k]);
      assign take    = rem_ext >= trial;

      always_comb begin
         q_in    = q_ff[k];
         q_in[B] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[k+1] <= tag_ff[k];
            den_ff[k+1] <= den_ff[k];
            rem_ff[k+1] <= take ? NW'(rem_ext - trial) : rem_ff[k];
            q_ff[k+1]   <= q_in;
         end
      end
   end

   assign out_valid = v_ff[QB];
   assign out_tag   = tag_ff[QB];
   assign quot      = q_ff[QB];

endmodule

@@ rtl/core/psd3d_sqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, digit by digit, rounded down.
// ----------------------------------------------------------------------------
module psd3d_sqrt
   import psd3d_pkg::*;
#(
   parameter int QB = 50
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  tag_type         in_tag,
   input  logic [QB-1:0]   rad,
   output logic            out_valid,
   output tag_type         out_tag,
   output logic [QB/2-1:0] root
);

   localparam int RB = QB / 2;
   localparam int XW = QB + 1;

   logic [RB:0]   v_ff;
   tag_type       tag_ff [RB+1];
   logic [XW-1:0] x_ff   [RB+1];
   logic [RB-1:0] r_ff   [RB+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= in_tag;
         x_ff[0]   <= XW'(rad);
         r_ff[0]   <= '0;
      end
   end

   for (genvar k = 0; k < RB; k++) begin : g_stage
      localparam int B = RB - 1 - k;
      logic [XW-1:0] step;
      logic          take;
      logic [RB-1:0] r_in;

      assign step = (XW'(r_ff[k]) << (B + 1)) | (XW'(1) << (2 * B));
      assign take = x_ff[k] >= step;

      always_comb begin
         r_in    = r_ff[k];
         r_in[B] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[k+1] <= tag_ff[k];
            x_ff[k+1]   <= take ? x_ff[k] - step : x_ff[k];
            r_ff[k+1]   <= r_in;
         end
      end
   end

   assign out_valid = v_ff[RB];
   assign out_tag   = tag_ff[RB];
   assign root      = r_ff[RB];

endmodule

@@ rtl/core/point_segment_distance_3d_unit.sv @@
// Throughput: one query per cycle while the output is not stalled, set by the fully pipelined divider and root stages.
// The whole pipeline holds while a finished result waits at the output.
// Reset clears every stage valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
// Point to segment distance unit
// Distance from P to segment AB with the case code, in a deep pipeline.
// ----------------------------------------------------------------------------
module point_segment_distance_3d_unit
   import psd3d_pkg::*;
#(
   parameter int COORD_BITS = 24
) (
   input  logic     clock,
   input  logic     reset,
   psd3d_req_if.sink   req,
   psd3d_rsp_if.source rsp
);

   localparam int DW   = COORD_BITS + 1;
   localparam int PW   = 2 * DW;
   localparam int SW   = PW + 1;
   localparam int DOTW = PW + 2;
   localparam int CW   = PW + 1;
   localparam int H    = (PW + 1) / 2;
   localparam int HW   = PW - H;
   localparam int NW   = 2 * PW + 2;
   localparam int QB   = 2 * DIST_BITS;

   logic en;
   logic [4:0] v_ff;

   assign en        = rsp.ready | ~rsp.valid;
   assign req.ready = en;

   // Stage 1: differences.
   logic signed [DW-1:0] ab_in [3];
   logic signed [DW-1:0] ap_in [3];
   logic signed [DW-1:0] bp_in [3];
   logic signed [DW-1:0] ab_ff [3];
   logic signed [DW-1:0] ap_ff [3];
   logic signed [DW-1:0] bp_ff [3];

   assign ab_in[0] = DW'(req.b_x) - DW'(req.a_x);
   assign ab_in[1] = DW'(req.b_y) - DW'(req.a_y);
   assign ab_in[2] = DW'(req.b_z) - DW'(req.a_z);
   assign ap_in[0] = DW'(req.p_x) - DW'(req.a_x);
   assign ap_in[1] = DW'(req.p_y) - DW'(req.a_y);
   assign ap_in[2] = DW'(req.p_z) - DW'(req.a_z);
   assign bp_in[0] = DW'(req.p_x) - DW'(req.b_x);
   assign bp_in[1] = DW'(req.p_y) - DW'(req.b_y);
   assign bp_in[2] = DW'(req.p_z) - DW'(req.b_z);

   // Stage 2: products.
   logic signed [PW-1:0] abab_ff [3];
   logic signed [PW-1:0] apab_ff [3];
   logic signed [PW-1:0] apap_ff [3];
   logic signed [PW-1:0] bpbp_ff [3];
   logic signed [PW-1:0] xp_ff   [6];

   // Stage 3: sums and cross product magnitudes.
   logic [SW-1:0]          len2_ff;
   logic signed [DOTW-1:0] dot_ff;
   logic [SW-1:0]          apsq_ff;
   logic [SW-1:0]          bpsq_ff;
   logic [PW-1:0]          crabs_ff [3];
   logic signed [CW-1:0]   cr_in    [3];

   assign cr_in[0] = CW'(xp_ff[0]) - CW'(xp_ff[1]);
   assign cr_in[1] = CW'(xp_ff[2]) - CW'(xp_ff[3]);
   assign cr_in[2] = CW'(xp_ff[4]) - CW'(xp_ff[5]);

   // Stage 4: case decision and split squares.
   case_type               kase_in;
   case_type               kase4_ff;
   logic [SW-1:0]          len2_4_ff;
   logic [SW-1:0]          apsq4_ff;
   logic [SW-1:0]          bpsq4_ff;
   logic [2*HW-1:0]        hh_ff [3];
   logic [PW-1:0]          hl_ff [3];
   logic [2*H-1:0]         ll_ff [3];
   logic signed [DOTW-1:0] len2_s;

   assign len2_s = DOTW'($signed({1'b0, len2_ff}));

   always_comb begin
      if (len2_ff == '0) begin
         kase_in = CASE_DEGEN;
      end else if (dot_ff <= 0) begin
         kase_in = CASE_NEAR_A;
      end else if (dot_ff >= len2_s) begin
         kase_in = CASE_NEAR_B;
      end else begin
         kase_in = CASE_INTERIOR;
      end
   end

   // Stage 5: operand selection for the divider.
   logic [NW-1:0] crnum;
   logic [NW-1:0] num_in;
   logic [SW-1:0] den_in;
   logic [NW-1:0] num_ff;
   logic [SW-1:0] den_ff;
   tag_type       tag5_ff;

   always_comb begin
      crnum = '0;
      for (int i = 0; i < 3; i++) begin
         crnum = crnum + (NW'(hh_ff[i]) << (2 * H)) + (NW'(hl_ff[i]) << (H + 1))
               + NW'(ll_ff[i]);
      end
   end

   always_comb begin
      case (kase4_ff)
         CASE_INTERIOR: begin
            num_in = crnum;
            den_in = len2_4_ff;
         end
         CASE_NEAR_B: begin
            num_in = NW'(bpsq4_ff);
            den_in = SW'(1);
         end
         default: begin
            num_in = NW'(apsq4_ff);
            den_in = SW'(1);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], req.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            ab_ff[i]   <= ab_in[i];
            ap_ff[i]   <= ap_in[i];
            bp_ff[i]   <= bp_in[i];
            abab_ff[i] <= ab_ff[i] * ab_ff[i];
            apab_ff[i] <= ap_ff[i] * ab_ff[i];
            apap_ff[i] <= ap_ff[i] * ap_ff[i];
            bpbp_ff[i] <= bp_ff[i] * bp_ff[i];
            crabs_ff[i] <= PW'(cr_in[i][CW-1] ? -cr_in[i] : cr_in[i]);
            hh_ff[i]   <= crabs_ff[i][PW-1:H] * crabs_ff[i][PW-1:H];
            hl_ff[i]   <= crabs_ff[i][PW-1:H] * crabs_ff[i][H-1:0];
            ll_ff[i]   <= crabs_ff[i][H-1:0] * crabs_ff[i][H-1:0];
         end
         xp_ff[0] <= ap_ff[1] * ab_ff[2];
         xp_ff[1] <= ap_ff[2] * ab_ff[1];
         xp_ff[2] <= ap_ff[2] * ab_ff[0];
         xp_ff[3] <= ap_ff[0] * ab_ff[2];
         xp_ff[4] <= ap_ff[0] * ab_ff[1];
         xp_ff[5] <= ap_ff[1] * ab_ff[0];
         len2_ff  <= SW'(abab_ff[0]) + SW'(abab_ff[1]) + SW'(abab_ff[2]);
         dot_ff   <= DOTW'(apab_ff[0]) + DOTW'(apab_ff[1]) + DOTW'(apab_ff[2]);
         apsq_ff  <= SW'(apap_ff[0]) + SW'(apap_ff[1]) + SW'(apap_ff[2]);
         bpsq_ff  <= SW'(bpbp_ff[0]) + SW'(bpbp_ff[1]) + SW'(bpbp_ff[2]);
         kase4_ff  <= kase_in;
         len2_4_ff <= len2_ff;
         apsq4_ff  <= apsq_ff;
         bpsq4_ff  <= bpsq_ff;
         num_ff    <= num_in;
         den_ff    <= den_in;
         tag5_ff   <= '{sat: 1'b0, kase: kase4_ff};
      end
   end

   logic          div_valid;
   tag_type       div_tag;
   logic [QB-1:0] div_quot;

   psd3d_div #(
      .NW   (NW),
      .DENW (SW),
      .QB   (QB)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v_ff[4]),
      .in_tag    (tag5_ff),
      .num       (num_ff),
      .den       (den_ff),
      .out_valid (div_valid),
      .out_tag   (div_tag),
      .quot      (div_quot)
   );

   logic                 sq_valid;
   tag_type              sq_tag;
   logic [DIST_BITS-1:0] sq_root;

   psd3d_sqrt #(
      .QB (QB)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_tag    (div_tag),
      .rad       (div_quot),
      .out_valid (sq_valid),
      .out_tag   (sq_tag),
      .root      (sq_root)
   );

   assign rsp.valid        = sq_valid;
   assign rsp.distance     = sq_tag.sat ? '1 : sq_root;
   assign rsp.nearest_case = sq_tag.kase;

endmodule
